[rtl/core/cdtimer_pkg.sv]
// Shared types, constants and the segment decoder for the countdown timer.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package cdtimer_pkg;

    localparam int unsigned TIME_W = 20;
    localparam int unsigned STEP_W = 7;
    localparam int unsigned SW_W   = 10;
    localparam int unsigned BTN_W  = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned SEG_W  = 7;

    typedef logic [TIME_W-1:0] time_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEFAULT_TIME = 2'd0,
        CFG_ADD_STEP     = 2'd1,
        CFG_TIME_LIMIT   = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_idx_t;

    localparam logic [BTN_W-1:0] BTN_START = 4'd1;
    localparam logic [BTN_W-1:0] BTN_STOP  = 4'd2;
    localparam logic [BTN_W-1:0] BTN_ADD   = 4'd4;
    localparam logic [BTN_W-1:0] BTN_CLEAR = 4'd8;

    localparam time_t             RST_DEFAULT_TIME = 20'd300;
    localparam logic [STEP_W-1:0] RST_ADD_STEP     = 7'd10;
    localparam time_t             RST_TIME_LIMIT   = 20'd999999;
    localparam time_t             TIME_MAX         = 20'hFFFFF;

    // Reciprocals: floor(t / d) = (t * M) >> K for every 20-bit t
    localparam logic [19:0] RECIP_10    = 20'd838861;
    localparam logic [19:0] RECIP_100   = 20'd671089;
    localparam logic [19:0] RECIP_1000  = 20'd536871;
    localparam logic [19:0] RECIP_6000  = 20'd715828;
    localparam logic [20:0] RECIP_60000 = 21'd1145325;

    localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67
    };

    function automatic logic [SEG_W-1:0] seg_code(input logic [4:0] d);
        logic [SEG_W-1:0] code;
        code = '0;
        if (d < 5'd10)
        begin
            code = SEG_TABLE[d[3:0]];
        end
        return code;
    endfunction

endpackage

[rtl/core/countdown_timer_seven_segment.sv]
// Countdown timer with MM:SS.hh seven-segment display, one polling beat per unstalled cycle.
// Depends on cdtimer_pkg (constants, reciprocals, segment decoder).
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_stall, switches, buttons, tick    | in
//  result  | out_valid, out_stall, time_left, hex_low,      | out
//          | hex_high, led_on, running                      |
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data      | in
//
// One input beat per cycle unless the result stalls; its result is registered in a, b, out.
// Timer state updates at acceptance; two stages of constant-reciprocal
// multipliers and digit decoding build the display.
// Reset loads 300 hundredths, stopped, LED lit, display blank; cfg_ready stays high.
// A stalled valid result freezes the pipeline; in_stall is out_stall gated by out_valid.
`timescale 1ns / 1ps

module countdown_timer_seven_segment (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [cdtimer_pkg::SW_W-1:0]       switches,
    input  logic [cdtimer_pkg::BTN_W-1:0]      buttons,
    input  logic                               tick,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [cdtimer_pkg::TIME_W-1:0]     time_left,
    output logic [30:0]                        hex_low,
    output logic [14:0]                        hex_high,
    output logic                               led_on,
    output logic                               running,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cdtimer_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cdtimer_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cdtimer_pkg::*;

    function automatic logic [3:0] mul10_lo(input logic [3:0] v);
        return 4'({v, 3'b000} + {v, 1'b0});
    endfunction

    function automatic logic [3:0] mul6_lo(input logic [3:0] v);
        return 4'({v, 2'b00} + {v, 1'b0});
    endfunction

    // Configuration
    time_t             default_time_reg;
    logic [STEP_W-1:0] add_step_reg;
    time_t             time_limit_reg;

    // Timer state
    time_t time_reg, time_next;
    logic  run_reg, run_next;
    logic  led_reg, led_next;

    // Pipeline
    logic  advance;
    logic  accept;

    logic  a_valid_reg;
    time_t a_disp_reg;
    logic  a_refresh_reg;
    time_t a_time_reg;
    logic  a_led_reg;
    logic  a_run_reg;

    logic       b_valid_reg;
    logic [3:0] b_t_lo_reg;
    logic [3:0] b_q10_reg;
    logic [3:0] b_q100_reg;
    logic [3:0] b_q1000_reg;
    logic [3:0] b_q6000_reg;
    logic [4:0] b_q60000_reg;
    logic       b_refresh_reg;
    time_t      b_time_reg;
    logic       b_led_reg;
    logic       b_run_reg;

    logic        out_valid_reg;
    time_t       out_time_reg;
    logic        out_led_reg;
    logic        out_run_reg;
    logic [30:0] shown_low_reg;
    logic [14:0] shown_high_reg;

    time_t       disp_next;
    logic        refresh_next;
    logic [20:0] add_sum;

    logic [39:0] p10;
    logic [39:0] p100;
    logic [39:0] p1000;
    logic [39:0] p6000;
    logic [40:0] p60000;

    logic [3:0]  d_hund;
    logic [3:0]  d_tenth;
    logic [3:0]  d_sec;
    logic [3:0]  d_tsec;
    logic [3:0]  d_min;
    logic [30:0] low_next;
    logic [14:0] high_next;

    assign advance   = !(out_valid_reg && out_stall);
    assign accept    = in_valid && advance;
    assign in_stall  = !advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_time_reg <= RST_DEFAULT_TIME;
            add_step_reg     <= RST_ADD_STEP;
            time_limit_reg   <= RST_TIME_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEFAULT_TIME: default_time_reg <= cfg_data[TIME_W-1:0];
                CFG_ADD_STEP:     add_step_reg     <= cfg_data[STEP_W-1:0];
                CFG_TIME_LIMIT:   time_limit_reg   <= cfg_data[TIME_W-1:0];
                default:          ;
            endcase
        end
    end

    // Button handling, zero check and tick decrement
    always_comb
    begin
        time_next    = time_reg;
        run_next     = run_reg;
        led_next     = led_reg;
        refresh_next = 1'b0;
        add_sum      = {1'b0, time_reg} + {14'd0, add_step_reg};
        if (switches == '0)
        begin
            refresh_next = 1'b1;
            unique case (buttons)
                BTN_START: run_next = 1'b1;
                BTN_STOP:  run_next = 1'b0;
                BTN_ADD:
                begin
                    led_next = 1'b1;
                    if (time_reg < time_limit_reg)
                    begin
                        time_next = add_sum[20] ? TIME_MAX : add_sum[TIME_W-1:0];
                    end
                end
                BTN_CLEAR:
                begin
                    time_next = default_time_reg;
                    led_next  = 1'b1;
                end
                default: ;
            endcase
        end
        disp_next = time_next;
        if (time_next == '0)
        begin
            led_next = 1'b0;
            run_next = 1'b0;
        end
        if (tick && run_next && (time_next != '0))
        begin
            time_next = time_next - 20'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= RST_DEFAULT_TIME;
            run_reg  <= 1'b0;
            led_reg  <= 1'b1;
        end
        else if (accept)
        begin
            time_reg <= time_next;
            run_reg  <= run_next;
            led_reg  <= led_next;
        end
    end

    // Quotients of the display time
    assign p10    = 40'(a_disp_reg) * 40'(RECIP_10);
    assign p100   = 40'(a_disp_reg) * 40'(RECIP_100);
    assign p1000  = 40'(a_disp_reg) * 40'(RECIP_1000);
    assign p6000  = 40'(a_disp_reg) * 40'(RECIP_6000);
    assign p60000 = 41'(a_disp_reg) * 41'(RECIP_60000);

    // Digits from adjacent quotients, then segment codes
    always_comb
    begin
        d_hund    = b_t_lo_reg  - mul10_lo(b_q10_reg);
        d_tenth   = b_q10_reg   - mul10_lo(b_q100_reg);
        d_sec     = b_q100_reg  - mul10_lo(b_q1000_reg);
        d_tsec    = b_q1000_reg - mul6_lo(b_q6000_reg);
        d_min     = b_q6000_reg - mul10_lo(b_q60000_reg[3:0]);
        low_next  = {seg_code({1'b0, d_tsec}), 1'b0,
                     seg_code({1'b0, d_sec}), 1'b0,
                     seg_code({1'b0, d_tenth}), 1'b0,
                     seg_code({1'b0, d_hund})};
        high_next = {seg_code(b_q60000_reg), 1'b0, seg_code({1'b0, d_min})};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            shown_low_reg  <= '0;
            shown_high_reg <= '0;
        end
        else if (advance)
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
            if (b_valid_reg && b_refresh_reg)
            begin
                shown_low_reg  <= low_next;
                shown_high_reg <= high_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_disp_reg    <= disp_next;
            a_refresh_reg <= refresh_next;
            a_time_reg    <= time_next;
            a_led_reg     <= led_next;
            a_run_reg     <= run_next;

            b_t_lo_reg    <= a_disp_reg[3:0];
            b_q10_reg     <= p10[26:23];
            b_q100_reg    <= p100[29:26];
            b_q1000_reg   <= p1000[32:29];
            b_q6000_reg   <= p6000[35:32];
            b_q60000_reg  <= p60000[40:36];
            b_refresh_reg <= a_refresh_reg;
            b_time_reg    <= a_time_reg;
            b_led_reg     <= a_led_reg;
            b_run_reg     <= a_run_reg;

            out_time_reg  <= b_time_reg;
            out_led_reg   <= b_led_reg;
            out_run_reg   <= b_run_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign time_left = out_time_reg;
    assign hex_low   = shown_low_reg;
    assign hex_high  = shown_high_reg;
    assign led_on    = out_led_reg;
    assign running   = out_run_reg;

endmodule

[tb/sv/cdtimer_monitor.sv]
// Checker for the countdown timer: watches the input, result and register channels,
// predicts each polling result and compares it. Depends on cdtimer_pkg.
`timescale 1ns / 1ps

module cdtimer_monitor (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [cdtimer_pkg::SW_W-1:0]       switches,
    input  logic [cdtimer_pkg::BTN_W-1:0]      buttons,
    input  logic                               tick,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [cdtimer_pkg::TIME_W-1:0]     time_left,
    input  logic [30:0]                        hex_low,
    input  logic [14:0]                        hex_high,
    input  logic                               led_on,
    input  logic                               running,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [cdtimer_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cdtimer_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                 mismatches,
    output int                                 pending,
    output int                                 checked,
    output int                                 expiries
);
    import cdtimer_pkg::*;

    typedef struct packed {
        time_t       t;
        logic [30:0] lo;
        logic [14:0] hi;
        logic        led;
        logic        run;
    } timer_view_t;

    timer_view_t       awaited_views[$];
    time_t             dflt_q;
    logic [STEP_W-1:0] step_q;
    time_t             limit_q;
    time_t             time_q;
    logic              run_q;
    logic              led_q;
    logic [30:0]       lo_q;
    logic [14:0]       hi_q;
    int                bad_count;
    int                expiry_count;
    int                result_count;

    function automatic logic [6:0] digit_segments(input int unsigned d);
        logic [6:0] code;
        unique case (d)
            0: code = 7'h3F;
            1: code = 7'h06;
            2: code = 7'h5B;
            3: code = 7'h4F;
            4: code = 7'h66;
            5: code = 7'h6D;
            6: code = 7'h7D;
            7: code = 7'h07;
            8: code = 7'h7F;
            9: code = 7'h67;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

    function automatic void store_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        unique case (cfg_idx_t'(idx))
            CFG_DEFAULT_TIME: dflt_q = data;
            CFG_ADD_STEP:     step_q = data[STEP_W-1:0];
            CFG_TIME_LIMIT:   limit_q = data;
            default: ;
        endcase
    endfunction

    function automatic timer_view_t poll_pass(input logic [SW_W-1:0] sw,
                                              input logic [BTN_W-1:0] btn,
                                              input logic tk);
        logic [TIME_W:0] sum;
        int unsigned     t;
        timer_view_t     v;
        if (sw == '0)
        begin
            unique case (btn)
                BTN_START: run_q = 1'b1;
                BTN_STOP:  run_q = 1'b0;
                BTN_ADD:
                begin
                    led_q = 1'b1;
                    if (time_q < limit_q)
                    begin
                        sum = {1'b0, time_q} + step_q;
                        time_q = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
                    end
                end
                BTN_CLEAR:
                begin
                    time_q = dflt_q;
                    led_q = 1'b1;
                end
                default: ;
            endcase
            t = time_q;
            lo_q = {digit_segments((t / 1000) % 6), 1'b0, digit_segments((t / 100) % 10), 1'b0,
                    digit_segments((t / 10) % 10), 1'b0, digit_segments(t % 10)};
            hi_q = {digit_segments(t / 60000), 1'b0, digit_segments((t / 6000) % 10)};
        end
        if (time_q == '0)
        begin
            if (run_q)
            begin
                expiry_count++;
            end
            led_q = 1'b0;
            run_q = 1'b0;
        end
        if (tk && run_q && time_q != '0)
        begin
            time_q = time_q - 1'b1;
        end
        v = '{t: time_q, lo: lo_q, hi: hi_q, led: led_q, run: run_q};
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        timer_view_t seen;
        timer_view_t want;
        if (!rst_n)
        begin
            awaited_views.delete();
            dflt_q = RST_DEFAULT_TIME;
            step_q = RST_ADD_STEP;
            limit_q = RST_TIME_LIMIT;
            time_q = RST_DEFAULT_TIME;
            run_q = 1'b0;
            led_q = 1'b1;
            lo_q = '0;
            hi_q = '0;
            bad_count = 0;
            expiry_count = 0;
            result_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                store_register(cfg_index, cfg_data);
            end
            if (in_valid && !in_stall)
            begin
                awaited_views.push_back(poll_pass(switches, buttons, tick));
            end
            if (out_valid && !out_stall)
            begin
                seen = '{t: time_left, lo: hex_low, hi: hex_high, led: led_on, run: running};
                result_count++;
                if (awaited_views.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                    begin
                        $display("[%0t] result beat with nothing awaited: time %0d", $realtime,
                                 time_left);
                    end
                end
                else
                begin
                    want = awaited_views.pop_front();
                    if (seen !== want)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                        begin
                            $display("[%0t] result %0d differs (expected / actual):", $realtime,
                                     result_count);
                            $display("    time_left %0d / %0d, hex_low %h / %h, hex_high %h / %h",
                                     want.t, seen.t, want.lo, seen.lo, want.hi, seen.hi);
                            $display("    led_on %b / %b, running %b / %b",
                                     want.led, seen.led, want.run, seen.run);
                        end
                    end
                end
            end
        end
        mismatches <= bad_count;
        pending <= awaited_views.size();
        checked <= result_count;
        expiries <= expiry_count;
    end

endmodule

[tb/sv/countdown_timer_seven_segment_tb.sv]
// Testbench top for the countdown timer: clock, reset, register programming,
// directed and random polling beats with idling phases. Depends on cdtimer_pkg, cdtimer_monitor.
`timescale 1ns / 1ps

module countdown_timer_seven_segment_tb;

    import cdtimer_pkg::*;

    localparam int HOLD_CYCLES = 60;
    localparam int RANDOM_PHASES = 10;
    localparam int BEATS_PER_PHASE = 125;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [SW_W-1:0]       switches;
    logic [BTN_W-1:0]      buttons;
    logic                  tick;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [TIME_W-1:0]     time_left;
    logic [30:0]           hex_low;
    logic [14:0]           hex_high;
    logic                  led_on;
    logic                  running;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int   mismatches;
    int   pending;
    int   checked;
    int   expiries;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   beats_sent = 0;
    int   settings_used = 0;
    int   hold_left = 0;
    logic hold_arm = 1'b0;
    logic hold_seen = 1'b0;

    countdown_timer_seven_segment dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .switches  (switches),
        .buttons   (buttons),
        .tick      (tick),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .time_left (time_left),
        .hex_low   (hex_low),
        .hex_high  (hex_high),
        .led_on    (led_on),
        .running   (running),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cdtimer_monitor monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .switches   (switches),
        .buttons    (buttons),
        .tick       (tick),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .time_left  (time_left),
        .hex_low    (hex_low),
        .hex_high   (hex_high),
        .led_on     (led_on),
        .running    (running),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked),
        .expiries   (expiries)
    );

    always #5 clk = ~clk;

    // Hold off the result channel for a long stretch on request, else stall at random
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_arm != hold_seen)
        begin
            hold_seen <= hold_arm;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic send_poll(input logic [SW_W-1:0] sw, input logic [BTN_W-1:0] btn,
                             input logic tk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        switches <= sw;
        buttons <= btn;
        tick <= tk;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic program_timer(input time_t dflt, input int unsigned step,
                                 input time_t limit);
        write_reg(CFG_DEFAULT_TIME, dflt);
        write_reg(CFG_ADD_STEP, CFG_DATA_W'(step));
        write_reg(CFG_TIME_LIMIT, limit);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_random_poll;
        logic [SW_W-1:0]  sw;
        logic [BTN_W-1:0] btn;
        int               pick;
        sw = ($urandom_range(99) < 85) ? '0 : SW_W'($urandom_range(1, 1023));
        pick = $urandom_range(99);
        if (pick < 20)
            btn = BTN_START;
        else if (pick < 28)
            btn = BTN_STOP;
        else if (pick < 43)
            btn = BTN_ADD;
        else if (pick < 50)
            btn = BTN_CLEAR;
        else if (pick < 65)
            btn = BTN_W'($urandom_range(15));
        else
            btn = '0;
        send_poll(sw, btn, $urandom_range(99) < 70);
    endtask

    initial
    begin
        time_t dflt;
        time_t limit;
        rst_n = 1'b0;
        in_valid = 1'b0;
        switches = '0;
        buttons = '0;
        tick = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DEFAULT_TIME;
        cfg_data = '0;
        repeat (4)
        begin
            @(negedge clk);
        end
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: idle refresh, start, switch masking, odd button words
        send_poll('0, '0, 1'b0);
        send_poll('0, '0, 1'b1);
        send_poll('0, BTN_START, 1'b0);
        send_poll('0, '0, 1'b1);
        send_poll('1, BTN_STOP, 1'b1);
        send_poll(10'h155, BTN_CLEAR, 1'b0);
        send_poll('0, BTN_ADD, 1'b1);
        send_poll('0, 4'hF, 1'b1);
        send_poll('0, 4'h3, 1'b0);
        send_poll('0, BTN_STOP, 1'b1);
        send_poll('0, BTN_CLEAR, 1'b0);
        drain();

        // Count down from one hundredth to expiry, then tick at zero
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        program_timer(20'd1, 100, 20'd999999);
        send_poll('0, BTN_CLEAR, 1'b0);
        send_poll('0, BTN_START, 1'b1);
        send_poll('0, '0, 1'b1);
        send_poll('0, BTN_START, 1'b1);
        send_poll('0, BTN_ADD, 1'b0);
        drain();

        // Tens of minutes above nine blank, add refused at the limit
        program_timer(20'd999999, 1, 20'd0);
        send_poll('0, BTN_CLEAR, 1'b0);
        send_poll('0, BTN_ADD, 1'b0);
        send_poll('0, BTN_START, 1'b1);
        send_poll(10'h2AA, '0, 1'b1);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            unique case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 86;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 86;
                end
                default:
                begin
                    send_idle_pct = 13;
                    stall_pct = 13;
                end
            endcase
            if (p == 0)
            begin
                program_timer(20'd0, 1, 20'd0);
            end
            else if (p == 1)
            begin
                program_timer(20'd999999, 100, 20'd999999);
            end
            else
            begin
                if ($urandom_range(3) == 0)
                    dflt = TIME_W'($urandom_range(999999));
                else if ($urandom_range(1) == 0)
                    dflt = TIME_W'($urandom_range(40));
                else
                    dflt = TIME_W'($urandom_range(400));
                if ($urandom_range(1) == 0)
                    limit = TIME_W'($urandom_range(999999));
                else
                    limit = (dflt > 999699) ? 20'd999999
                                            : TIME_W'(dflt + $urandom_range(300));
                program_timer(dflt, $urandom_range(1, 100), limit);
            end
            if (p == 4)
            begin
                hold_arm <= ~hold_arm;
            end
            repeat (BEATS_PER_PHASE)
            begin
                send_random_poll();
            end
            drain();
        end

        repeat (8)
        begin
            @(negedge clk);
        end
        $display("Covered %0d polling beats under %0d register settings, idle and stalled.",
                 beats_sent, settings_used);
        $display("Checked %0d results; the countdown expired %0d times.", checked, expiries);
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
